[design/tmd_pkg.sv]
// ----------------------------------------------------------------------------
// tmd_pkg
// Shared types and constants of the timed bidirectional motor drive.
// ----------------------------------------------------------------------------
package tmd_pkg;

    localparam int STEP_TIME_W     = 16;
    localparam int AMOUNT_W        = 8;
    localparam int PROD_W          = STEP_TIME_W + AMOUNT_W;
    localparam int REMAIN_W        = 18;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [AMOUNT_W-1:0] BUTTON_AMOUNT_RESET = 8'd25;

    // Exact floor division by 100 for any 24-bit dividend: (x * M) >> 31.
    localparam int                  DIV100_MAGIC_W = 25;
    localparam logic [DIV100_MAGIC_W-1:0] DIV100_MAGIC = 25'd21474837;
    localparam int                  DIV100_SHIFT   = 31;
    localparam int                  DIV100_PROD_W  = PROD_W + DIV100_MAGIC_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STEP_TIME     = 1'b0,
        CFG_BUTTON_AMOUNT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [PROD_W-1:0] prod;
        logic              left_clear;
        logic              right_clear;
        logic              left_button;
        logic              right_button;
    } tmd_item_t;

endpackage

[design/tmd_cfg.sv]
// ----------------------------------------------------------------------------
// tmd_cfg
// Configuration registers, with the button move length product kept ready.
// ----------------------------------------------------------------------------
module tmd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tmd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [tmd_pkg::STEP_TIME_W-1:0]  step_time_next,
    output logic [tmd_pkg::PROD_W-1:0]       button_prod
);
    import tmd_pkg::*;

    logic [STEP_TIME_W-1:0] step_time_reg;
    logic [AMOUNT_W-1:0]    button_amount_reg;
    logic [AMOUNT_W-1:0]    button_amount_next;
    logic [PROD_W-1:0]      button_prod_reg;
    logic [PROD_W-1:0]      button_prod_next;

    always_comb
    begin
        step_time_next     = step_time_reg;
        button_amount_next = button_amount_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_STEP_TIME:     step_time_next     = cfg_data[STEP_TIME_W-1:0];
                CFG_BUTTON_AMOUNT: button_amount_next = cfg_data[AMOUNT_W-1:0];
                default:           step_time_next     = step_time_reg;
            endcase
        end
        button_prod_next = {{AMOUNT_W{1'b0}}, step_time_next}
                         * {{STEP_TIME_W{1'b0}}, button_amount_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg     <= '0;
            button_amount_reg <= BUTTON_AMOUNT_RESET;
            button_prod_reg   <= '0;
        end
        else
        begin
            step_time_reg     <= step_time_next;
            button_amount_reg <= button_amount_next;
            button_prod_reg   <= button_prod_next;
        end
    end

    assign button_prod = button_prod_reg;

endmodule

[design/tmd_core.sv]
// ----------------------------------------------------------------------------
// tmd_core
// Drive state update and result register for one registered item.
// ----------------------------------------------------------------------------
module tmd_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  tmd_pkg::tmd_item_t          item,
    input  logic [tmd_pkg::PROD_W-1:0]  button_prod,
    output logic                        ready,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        drive_left,
    output logic                        drive_right,
    output logic                        move_accepted,
    output logic                        idle
);
    import tmd_pkg::*;

    logic                     advance;
    logic [PROD_W-1:0]        prod_sel;
    logic [DIV100_PROD_W-1:0] quot_wide;
    logic [REMAIN_W-1:0]      dur;
    logic                     start_req;
    logic                     start_left;
    logic                     start_ok;

    logic                out_valid_reg,     out_valid_next;
    logic                moving_left_reg,   moving_left_next;
    logic                moving_right_reg,  moving_right_next;
    logic [REMAIN_W-1:0] remaining_reg,     remaining_next;
    logic                left_seen_reg,     left_seen_next;
    logic                right_seen_reg,    right_seen_next;
    logic                left_drive_reg,    left_drive_next;
    logic                right_drive_reg,   right_drive_next;
    logic                accepted_reg,      accepted_next;
    logic                idle_reg,          idle_next;

    assign ready   = !out_valid_reg || !out_stall;
    assign advance = item_valid && ready;

    assign prod_sel  = (item.cmd == CMD_TICK) ? button_prod : item.prod;
    assign quot_wide = {{DIV100_MAGIC_W{1'b0}}, prod_sel}
                     * {{PROD_W{1'b0}}, DIV100_MAGIC};
    assign dur       = quot_wide[DIV100_SHIFT +: REMAIN_W];

    always_comb
    begin
        moving_left_next  = moving_left_reg;
        moving_right_next = moving_right_reg;
        remaining_next    = remaining_reg;
        left_seen_next    = left_seen_reg;
        right_seen_next   = right_seen_reg;
        left_drive_next   = left_drive_reg;
        right_drive_next  = right_drive_reg;
        start_req         = 1'b0;
        start_left        = 1'b0;
        start_ok          = 1'b0;

        case (item.cmd)
            CMD_TICK:
            begin
                left_seen_next  = item.left_clear;
                right_seen_next = item.right_clear;
                if (moving_left_reg)
                begin
                    if (item.left_clear && (remaining_reg != '0))
                    begin
                        left_drive_next = 1'b1;
                        remaining_next  = remaining_reg - REMAIN_W'(1);
                    end
                    else if (!item.left_button || !item.left_clear)
                    begin
                        left_drive_next  = 1'b0;
                        moving_left_next = 1'b0;
                    end
                end
                else if (moving_right_reg)
                begin
                    if (item.right_clear && (remaining_reg != '0))
                    begin
                        right_drive_next = 1'b1;
                        remaining_next   = remaining_reg - REMAIN_W'(1);
                    end
                    else if (!item.right_button || !item.right_clear)
                    begin
                        right_drive_next  = 1'b0;
                        moving_right_next = 1'b0;
                    end
                end
                else if (item.left_button)
                begin
                    start_req  = 1'b1;
                    start_left = 1'b1;
                end
                else if (item.right_button)
                begin
                    start_req = 1'b1;
                end
            end
            CMD_LEFT:
            begin
                start_req  = 1'b1;
                start_left = 1'b1;
            end
            CMD_RIGHT:
            begin
                start_req = 1'b1;
            end
            default:
            begin
                moving_left_next  = 1'b0;
                moving_right_next = 1'b0;
                left_drive_next   = 1'b0;
                right_drive_next  = 1'b0;
                remaining_next    = '0;
            end
        endcase

        if (start_req)
        begin
            moving_left_next  = 1'b0;
            moving_right_next = 1'b0;
            left_drive_next   = 1'b0;
            right_drive_next  = 1'b0;
            remaining_next    = '0;
            start_ok          = start_left ? left_seen_next : right_seen_next;
            if (start_ok)
            begin
                moving_left_next  = start_left;
                moving_right_next = !start_left;
                remaining_next    = dur;
            end
        end

        accepted_next  = start_ok;
        idle_next      = !(moving_left_next || moving_right_next);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            moving_left_reg  <= 1'b0;
            moving_right_reg <= 1'b0;
            remaining_reg    <= '0;
            left_seen_reg    <= 1'b0;
            right_seen_reg   <= 1'b0;
            left_drive_reg   <= 1'b0;
            right_drive_reg  <= 1'b0;
            accepted_reg     <= 1'b0;
            idle_reg         <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                moving_left_reg  <= moving_left_next;
                moving_right_reg <= moving_right_next;
                remaining_reg    <= remaining_next;
                left_seen_reg    <= left_seen_next;
                right_seen_reg   <= right_seen_next;
                left_drive_reg   <= left_drive_next;
                right_drive_reg  <= right_drive_next;
                accepted_reg     <= accepted_next;
                idle_reg         <= idle_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_left    = left_drive_reg;
    assign drive_right   = right_drive_reg;
    assign move_accepted = accepted_reg;
    assign idle          = idle_reg;

`ifndef ASSERT_OFF
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        !(moving_left_reg && moving_right_reg))
        else $error("Both directions are active at once.");

    a_drive_needs_motion: assert property (@(posedge clk) disable iff (!rst_n)
        (!left_drive_reg || moving_left_reg) && (!right_drive_reg || moving_right_reg))
        else $error("A drive is high for an inactive direction.");

    a_accept_releases: assert property (@(posedge clk) disable iff (!rst_n)
        accepted_reg |-> (!left_drive_reg && !right_drive_reg && !idle_reg))
        else $error("An accepted move left a drive high or the block idle.");

    a_idle_matches: assert property (@(posedge clk) disable iff (!rst_n)
        idle_reg == !(moving_left_reg || moving_right_reg))
        else $error("Idle flag disagrees with the direction state.");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |=> $stable(remaining_reg) && $stable(left_seen_reg))
        else $error("Drive state changed without an item.");
`endif

endmodule

[design/timed_bidirectional_motor_drive.sv]
// ----------------------------------------------------------------------------
// timed_bidirectional_motor_drive
// Timed two-direction actuator drive with end-of-travel inputs and buttons.
// ----------------------------------------------------------------------------
// The input channel takes one word per item: a millisecond tick carrying the
// sampled end-clear and button levels, a move left or right command with its
// percent of a step, or a stop. The output channel returns one word per item
// with both drive levels, whether a move was started and whether the block is
// idle. Items are taken on in_valid with in_stall low and results leave on
// out_valid with out_stall low.
// The input register holds an accepted item with its move length product; the
// core divides the product by one hundred and updates the drive state into
// the result register. Throughput is one word per cycle; the register stages
// advance whenever the receiver does not stall, so a stalled result holds and
// backs up the input. Configuration writes through cfg_we, cfg_index and
// cfg_data reach commands at once, the button product through its register;
// the user makes them while no word is in flight, unchecked by the block.
// Reset clears both directions, drives, timer and end samples, sets the step
// time to zero and the button move to twenty-five percent.
// ----------------------------------------------------------------------------
module timed_bidirectional_motor_drive (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       command,
    input  logic [tmd_pkg::AMOUNT_W-1:0]     move_amount,
    input  logic                             left_clear,
    input  logic                             right_clear,
    input  logic                             left_button,
    input  logic                             right_button,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             drive_left,
    output logic                             drive_right,
    output logic                             move_accepted,
    output logic                             idle,
    input  logic                             cfg_we,
    input  logic [tmd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tmd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tmd_pkg::*;

    logic [STEP_TIME_W-1:0] step_time_next;
    logic [PROD_W-1:0]      button_prod;
    logic                   core_ready;
    logic                   in_accept;

    logic                   item_valid_reg, item_valid_next;
    tmd_item_t              item_reg,       item_next;

    tmd_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .step_time_next (step_time_next),
        .button_prod    (button_prod)
    );

    assign in_stall  = item_valid_reg && !core_ready;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        item_next.cmd          = cmd_t'(command);
        item_next.prod         = {{AMOUNT_W{1'b0}}, step_time_next}
                               * {{STEP_TIME_W{1'b0}}, move_amount};
        item_next.left_clear   = left_clear;
        item_next.right_clear  = right_clear;
        item_next.left_button  = left_button;
        item_next.right_button = right_button;
        item_valid_next        = in_accept || (item_valid_reg && !core_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= item_next;
        end
    end

    tmd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid_reg),
        .item          (item_reg),
        .button_prod   (button_prod),
        .ready         (core_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_left    (drive_left),
        .drive_right   (drive_right),
        .move_accepted (move_accepted),
        .idle          (idle)
    );

endmodule
